FILE: hdl/vdi_pkg.sv
package vdi_pkg;

  localparam int COORD_W     = 16;
  localparam int FRAC_BITS   = 16;
  localparam int SCALAR_W    = FRAC_BITS + 1;
  localparam int PROD_W      = 2 * SCALAR_W;
  localparam int CONTRIB_W   = SCALAR_W + 1 + COORD_W;
  localparam int MAX_REGIONS = 64;
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int STEP_W      = $clog2(FRAC_BITS);
  localparam int ACC_W       = 39;
  localparam int OUT_W       = 38;

  localparam logic [SCALAR_W-1:0] SCALAR_ONE  = SCALAR_W'(1) << FRAC_BITS;
  localparam logic [SCALAR_W-1:0] SCALAR_ZERO = '0;
  localparam logic [ACC_W-1:0]    ACC_MAX     = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic [ACC_W-1:0]    ACC_MIN     = {1'b1, {(ACC_W - 1){1'b0}}};
  localparam logic [OUT_W-1:0]    OUT_MAX     = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0]    OUT_MIN     = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_DIV,
    ST_SCALE,
    ST_CLOSE,
    ST_ACCUM,
    ST_EMIT
  } vdi_state_t;

  typedef struct packed {
    logic load;
    logic classify;
    logic div_step;
    logic scale;
    logic close;
    logic accum;
    logic emit;
  } vdi_cmd_t;

  typedef struct packed {
    logic present;
    logic need_div;
    logic close_region;
    logic last_region;
    logic out_free;
  } vdi_status_t;

endpackage

FILE: hdl/vdi_ctrl.sv
module vdi_ctrl
  import vdi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  vdi_status_t status,
  output vdi_cmd_t    cmd
);

  vdi_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        step_nxt     = '0;
        if (!status.present) begin
          state_nxt = ST_CLOSE;
        end else if (status.need_div) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_SCALE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(FRAC_BITS - 1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (status.close_region) begin
          cmd.close = 1'b1;
          state_nxt = ST_ACCUM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = status.last_region ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/vdi_dpath.sv
module vdi_dpath
  import vdi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  vdi_cmd_t                  cmd,
  output vdi_status_t               status,
  input  logic signed [COORD_W-1:0] in_start_coord,
  input  logic signed [COORD_W-1:0] in_peak_coord,
  input  logic signed [COORD_W-1:0] in_end_coord,
  input  logic signed [COORD_W-1:0] in_instance_coord,
  input  logic signed [COORD_W-1:0] in_delta,
  input  logic                      in_axis_present,
  input  logic                      in_last_axis,
  input  logic                      in_last_region,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   out_adjustment
);

  logic signed [COORD_W-1:0] s_r, p_r, e_r, x_r, d_r;
  logic                      present_r, last_ax_r, last_rg_r;

  logic [SCALAR_W-1:0]         rs_r, f_r;
  logic [COORD_W:0]            rem_r;
  logic [COORD_W-1:0]          den_r;
  logic signed [CONTRIB_W-1:0] contrib_r;
  logic signed [ACC_W-1:0]     sum_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        out_valid_r;
  logic [OUT_W-1:0]            out_adj_r;

  logic                        range_one, outside, at_peak, below_peak;
  logic [COORD_W:0]            diff_xs, diff_ps, diff_ex, diff_ep;
  logic [COORD_W:0]            rem_sh;
  logic                        rem_ge;
  logic [PROD_W-1:0]           prod;
  logic signed [CONTRIB_W-1:0] contrib_full;
  logic                        count_ok;
  logic signed [ACC_W:0]       sum_ext;
  logic [ACC_W-1:0]            sum_sat;
  logic [OUT_W-1:0]            out_sat;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r       <= in_start_coord;
      p_r       <= in_peak_coord;
      e_r       <= in_end_coord;
      x_r       <= in_instance_coord;
      d_r       <= in_delta;
      present_r <= in_axis_present;
      last_ax_r <= in_last_axis;
      last_rg_r <= in_last_region;
    end
  end

  assign range_one  = (s_r > p_r) || (p_r > e_r) ||
                      ((s_r < 0) && (e_r > 0) && (p_r != 0)) || (p_r == 0);
  assign outside    = (x_r < s_r) || (x_r > e_r);
  assign at_peak    = (x_r == p_r);
  assign below_peak = (x_r < p_r);

  assign diff_xs = {x_r[COORD_W-1], x_r} - {s_r[COORD_W-1], s_r};
  assign diff_ps = {p_r[COORD_W-1], p_r} - {s_r[COORD_W-1], s_r};
  assign diff_ex = {e_r[COORD_W-1], e_r} - {x_r[COORD_W-1], x_r};
  assign diff_ep = {e_r[COORD_W-1], e_r} - {p_r[COORD_W-1], p_r};

  assign rem_sh = {rem_r[COORD_W-1:0], 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den_r});

  assign prod         = rs_r * f_r;
  assign contrib_full = $signed({1'b0, rs_r}) * d_r;
  assign count_ok     = (cnt_r < CNT_W'(MAX_REGIONS));

  assign sum_ext = (ACC_W + 1)'(sum_r) + (ACC_W + 1)'(contrib_r);
  assign sum_sat = (sum_ext[ACC_W] != sum_ext[ACC_W-1]) ?
                   (sum_ext[ACC_W] ? ACC_MIN : ACC_MAX) : sum_ext[ACC_W-1:0];
  assign out_sat = (sum_r[ACC_W-1] != sum_r[OUT_W-1]) ?
                   (sum_r[ACC_W-1] ? OUT_MIN : OUT_MAX) : sum_r[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      if (range_one || at_peak) begin
        f_r <= SCALAR_ONE;
      end else begin
        f_r <= SCALAR_ZERO;
      end
      if (below_peak) begin
        rem_r <= diff_xs;
        den_r <= diff_ps[COORD_W-1:0];
      end else begin
        rem_r <= diff_ex;
        den_r <= diff_ep[COORD_W-1:0];
      end
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      f_r   <= {f_r[SCALAR_W-2:0], rem_ge};
    end
    if (cmd.close) begin
      contrib_r <= count_ok ? contrib_full : '0;
    end
    if (cmd.emit) begin
      out_adj_r <= out_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r        <= SCALAR_ONE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scale) begin
        rs_r <= prod[FRAC_BITS +: SCALAR_W];
      end else if (cmd.close || cmd.emit) begin
        rs_r <= SCALAR_ONE;
      end
      if (cmd.close && count_ok) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.emit) begin
        cnt_r <= '0;
      end
      if (cmd.accum) begin
        sum_r <= sum_sat;
      end else if (cmd.emit) begin
        sum_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.present      = present_r;
  assign status.need_div     = !range_one && !outside && !at_peak;
  assign status.close_region = last_ax_r || last_rg_r;
  assign status.last_region  = last_rg_r;
  assign status.out_free     = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_adjustment = out_adj_r;

endmodule

FILE: hdl/variation_delta_interpolator.sv
// One request is taken at a time; the input stalls until its work is done.
// An axis that needs the tent division passes through the one-bit-per-cycle restoring
// divider before scaling; closing a region adds the accumulate step and closing a row
// the emit step; other requests skip the divider, and a stalled result adds its wait.
// A row result is registered from the emit state after its final request accumulates.
// Synchronous active-low reset sets the region scalar to one, clears the sum and count,
// and drops out_valid.
module variation_delta_interpolator
  import vdi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_start_coord,
  input  logic signed [COORD_W-1:0] in_peak_coord,
  input  logic signed [COORD_W-1:0] in_end_coord,
  input  logic signed [COORD_W-1:0] in_instance_coord,
  input  logic signed [COORD_W-1:0] in_delta,
  input  logic                      in_axis_present,
  input  logic                      in_last_axis,
  input  logic                      in_last_region,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   out_adjustment
);

  vdi_cmd_t    cmd;
  vdi_status_t status;

  vdi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vdi_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_start_coord    (in_start_coord),
    .in_peak_coord     (in_peak_coord),
    .in_end_coord      (in_end_coord),
    .in_instance_coord (in_instance_coord),
    .in_delta          (in_delta),
    .in_axis_present   (in_axis_present),
    .in_last_axis      (in_last_axis),
    .in_last_region    (in_last_region),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_adjustment    (out_adjustment)
  );

endmodule
